### src/dfe_pkg.sv
// ----------------------------------------------------------------------------
// dfe_pkg: shared types and constants of the delimited field extractor
// Item types of both stream channels, register indexes and window sizing.
// ----------------------------------------------------------------------------
package dfe_pkg;

	// Largest delimiter the match window can hold
	localparam int DelimMax = 8;
	// Width of a count that runs from zero up to DelimMax
	localparam int FillW = $clog2(DelimMax + 1);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_last;
		logic       text_empty;
	} text_item_t;

	typedef struct packed {
		logic [7:0] field_byte;
		logic       is_end;
		logic       is_null;
	} field_item_t;

	typedef enum logic [1:0] {
		CFG_DELIM_BYTES  = 2'd0,
		CFG_DELIM_LENGTH = 2'd1,
		CFG_FIELD_NUMBER = 2'd2
	} cfg_reg_t;

endpackage

### src/delimited_field_extractor.sv
// ----------------------------------------------------------------------------
// delimited_field_extractor: pass on one delimited field of a byte string
// Splits a byte stream on a delimiter of up to eight bytes and forwards the
// bytes of the selected field, closing each string with an end transaction.
// ----------------------------------------------------------------------------
// Takes one text byte per clock while text_stall is low. Each accepted
// transaction is worked into a result register that holds every output it
// causes: usually zero or one byte, and at the end of a string up to seven
// flushed window bytes behind that byte, plus the end transaction. The result
// register drains one transaction per clock while field_stall is low, and the
// input stalls unless the register is empty or holds a single transaction
// that leaves this cycle, so a new input transaction is taken in the cycle
// the last output of the one before it leaves. Configuration writes are always
// ready and take effect on the next transaction.
module delimited_field_extractor
	import dfe_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	output logic              text_stall,
	input  text_item_t        text_item,
	output logic              field_valid,
	input  logic              field_stall,
	output field_item_t       field_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [63:0]       cfg_data
);

	typedef byte_t [DelimMax-1:0] win_t;

	// Configuration registers
	logic [63:0]      delim_bytes_q;
	logic [3:0]       delim_len_q;
	logic [15:0]      field_num_q;

	// String state
	win_t             win_q;
	logic [FillW-1:0] fill_q;
	logic [15:0]      cur_field_q;
	logic             done_q;

	// Result register
	win_t             res_bytes_q;
	logic [FillW-1:0] res_cnt_q;
	logic             res_end_q;
	logic             res_null_q;

	// Next-state and result logic
	logic [FillW-1:0] len;
	logic             f_neg;
	logic             f_pos;
	logic             last;
	logic             step;
	logic             tgt_pre;
	logic             tgt_post;
	logic [FillW-1:0] drop_a;
	logic [FillW-1:0] drop_b;
	logic [FillW-1:0] fill_t;
	logic [FillW-1:0] fill_u;
	logic [FillW-1:0] fill_a;
	logic [FillW-1:0] fill_b;
	win_t             win_t_v;
	win_t             win_a;
	win_t             win_b;
	logic [15:0]      cur_a;
	logic             done_a;
	logic             hit;
	logic             emit;
	byte_t            emit_byte;
	win_t             ld_bytes;
	logic [FillW-1:0] ld_cnt;

	logic             in_acc;
	logic             out_acc;
	logic             last_one;

	// Move the window down by n entries; vacated entries read zero
	function automatic win_t shift_down(input win_t w, input logic [FillW-1:0] n);
		win_t r;
		r = '0;
		for (int i = 0; i < DelimMax; i++) begin
			for (int j = 0; j < DelimMax; j++) begin
				if (j == i + int'(n)) begin
					r[i] = w[j];
				end
			end
		end
		return r;
	endfunction

	function automatic byte_t delim_byte(input logic [63:0] d, input int i);
		byte_t r;
		r = '0;
		if (i < 8) begin
			r = d[8*i +: 8];
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	assign len   = (int'(delim_len_q) > DelimMax) ? FillW'(DelimMax) : FillW'(delim_len_q);
	assign f_neg = field_num_q[15];
	assign f_pos = !f_neg && (field_num_q != '0);
	assign last  = text_item.text_last || text_item.text_empty;
	assign step  = !text_item.text_empty && !f_neg;
	assign tgt_pre = f_pos && !done_q && (cur_field_q == field_num_q);

	always_comb begin
		win_a     = win_q;
		fill_a    = fill_q;
		cur_a     = cur_field_q;
		done_a    = done_q;
		emit      = 1'b0;
		emit_byte = '0;
		hit       = 1'b0;
		drop_a    = '0;
		fill_t    = fill_q;
		fill_u    = fill_q;
		win_t_v   = win_q;
		if (step) begin
			if (len == '0) begin
				fill_a    = '0;
				emit      = 1'b1;
				emit_byte = text_item.text_byte;
			end else begin
				// trim a window left over from a longer delimiter
				drop_a  = (fill_q >= len) ? fill_q - len + FillW'(1) : '0;
				fill_t  = fill_q - drop_a;
				win_t_v = shift_down(win_q, drop_a);
				for (int i = 0; i < DelimMax; i++) begin
					if (FillW'(i) == fill_t) begin
						win_t_v[i] = text_item.text_byte;
					end
				end
				fill_u = fill_t + FillW'(1);
				if (fill_u == len) begin
					hit = 1'b1;
					for (int i = 0; i < DelimMax; i++) begin
						if (FillW'(i) < len && win_t_v[i] != delim_byte(delim_bytes_q, i)) begin
							hit = 1'b0;
						end
					end
					if (hit) begin
						if (tgt_pre) begin
							done_a = 1'b1;
						end
						if (cur_field_q != 16'hFFFF) begin
							cur_a = cur_field_q + 16'd1;
						end
						fill_a = '0;
						win_a  = win_t_v;
					end else begin
						emit      = tgt_pre;
						emit_byte = win_t_v[0];
						win_a     = shift_down(win_t_v, FillW'(1));
						fill_a    = len - FillW'(1);
					end
				end else begin
					win_a  = win_t_v;
					fill_a = fill_u;
				end
			end
		end
	end

	// End of string: trim and flush what is left of the window
	always_comb begin
		drop_b   = (!f_neg && len != '0 && fill_a >= len) ? fill_a - len + FillW'(1) : '0;
		win_b    = shift_down(win_a, drop_b);
		fill_b   = fill_a - drop_b;
		tgt_post = f_pos && !done_a && (cur_a == field_num_q) && (len != '0);
		for (int i = 0; i < DelimMax; i++) begin
			if (emit) begin
				ld_bytes[i] = (i == 0) ? emit_byte : win_b[(i > 0) ? i - 1 : 0];
			end else begin
				ld_bytes[i] = win_b[i];
			end
		end
		ld_cnt = emit ? FillW'(1) : '0;
		if (last && tgt_post) begin
			ld_cnt = ld_cnt + fill_b;
		end
	end

	assign field_valid = (res_cnt_q != '0) || res_end_q;
	assign last_one    = (res_cnt_q == FillW'(1) && !res_end_q) ||
		(res_cnt_q == '0 && res_end_q);
	assign text_stall  = field_valid && !(last_one && !field_stall);
	assign in_acc      = text_valid && !text_stall;
	assign out_acc     = field_valid && !field_stall;

	always_comb begin
		field_item.field_byte = (res_cnt_q != '0) ? res_bytes_q[0] : '0;
		field_item.is_end     = (res_cnt_q == '0);
		field_item.is_null    = (res_cnt_q == '0) && res_null_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_bytes_q <= '0;
			delim_len_q   <= 4'd1;
			field_num_q   <= 16'd1;
			fill_q        <= '0;
			cur_field_q   <= 16'd1;
			done_q        <= 1'b0;
			res_cnt_q     <= '0;
			res_end_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DELIM_BYTES:  delim_bytes_q <= cfg_data;
					CFG_DELIM_LENGTH: delim_len_q   <= cfg_data[3:0];
					CFG_FIELD_NUMBER: field_num_q   <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				if (last) begin
					fill_q      <= '0;
					cur_field_q <= 16'd1;
					done_q      <= 1'b0;
				end else begin
					fill_q      <= fill_a;
					cur_field_q <= cur_a;
					done_q      <= done_a;
				end
				res_cnt_q <= ld_cnt;
				res_end_q <= last;
			end else if (out_acc) begin
				if (res_cnt_q != '0) begin
					res_cnt_q <= res_cnt_q - FillW'(1);
				end else begin
					res_end_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_q       <= win_a;
			res_bytes_q <= ld_bytes;
			res_null_q  <= f_neg;
		end else if (out_acc && res_cnt_q != '0) begin
			// advance the queued bytes
			res_bytes_q <= shift_down(res_bytes_q, FillW'(1));
		end
	end

	a_stall_holds_result: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && field_stall |-> text_stall)
		else $error("input accepted while a stalled result would be overwritten");

	a_end_clears_string: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last |=> fill_q == '0 && cur_field_q == 16'd1 && !done_q)
		else $error("string state not cleared after end of string");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(fill_q) < DelimMax)
		else $error("match window fill out of range");

	a_null_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		field_valid && field_item.is_null |-> field_item.is_end && field_item.field_byte == '0)
		else $error("null flag on a byte transaction");

endmodule

### bench/delimited_field_extractor_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delimited_field_extractor_tb: self-checking bench of the field extractor
// Drives byte strings under a range of delimiter and field settings, predicts
// every field transaction in a behavioral copy of the splitter and checks each
// one as it leaves, with random idling on both sides and one long hold-off.
// ----------------------------------------------------------------------------
module delimited_field_extractor_tb;
	import dfe_pkg::*;

	localparam logic [1:0] CFG_SPARE = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_stall;
	text_item_t  text_item = '0;
	logic        field_valid;
	logic        field_stall = 1'b0;
	field_item_t field_item;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	// Behavioral copy of the splitter: registers and per-string state
	logic [63:0]        dl_bytes = '0;
	logic [3:0]         dl_len = 4'd1;
	logic signed [15:0] fld_num = 16'sd1;
	byte_t              win [DelimMax];
	logic [3:0]         fill = '0;
	logic [15:0]        cur_fld = 16'd1;
	logic               fld_done = 1'b0;

	field_item_t pending_fields [$];
	byte_t       string_buf [$];
	field_item_t want;

	bit calm = 1'b0;
	int hold_left = 0;
	int n_fail = 0;
	int n_bytes = 0;
	int n_strings = 0;
	int n_results = 0;
	int n_nulls = 0;
	int n_writes = 0;

	delimited_field_extractor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_item  (text_item),
		.field_valid(field_valid),
		.field_stall(field_stall),
		.field_item (field_item),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int eff_len();
		return (dl_len > DelimMax) ? DelimMax : int'(dl_len);
	endfunction

	function automatic byte_t delim_at(int i);
		return dl_bytes[8*i +: 8];
	endfunction

	function automatic bit is_target(int f);
		return f >= 1 && !fld_done && int'(cur_fld) == f;
	endfunction

	function automatic void drop_oldest();
		if (fill != 0) begin
			for (int i = 1; i < fill; i++)
				win[i-1] = win[i];
			fill = fill - 4'd1;
		end
	endfunction

	function automatic void queue_field(byte_t b, logic e, logic n);
		field_item_t r;
		r.field_byte = b;
		r.is_end = e;
		r.is_null = n;
		pending_fields.push_back(r);
	endfunction

	function automatic void predict_split(text_item_t it);
		int f;
		int len;
		bit hit;
		bit last;
		f = fld_num;
		len = eff_len();
		last = it.text_last || it.text_empty;
		if (!it.text_empty && f >= 0) begin
			if (len == 0) begin
				fill = '0;
				queue_field(it.text_byte, 1'b0, 1'b0);
			end else begin
				// a shorter length set mid-string trims the window first
				while (fill >= len)
					drop_oldest();
				win[fill] = it.text_byte;
				fill = fill + 4'd1;
				if (fill == len) begin
					hit = 1'b1;
					for (int i = 0; i < len; i++)
						if (win[i] != delim_at(i))
							hit = 1'b0;
					if (hit) begin
						if (is_target(f))
							fld_done = 1'b1;
						if (cur_fld != 16'hffff)
							cur_fld = cur_fld + 16'd1;
						fill = '0;
					end else begin
						if (is_target(f))
							queue_field(win[0], 1'b0, 1'b0);
						drop_oldest();
					end
				end
			end
		end
		if (last) begin
			if (f >= 0 && len > 0) begin
				while (fill >= len)
					drop_oldest();
				if (is_target(f))
					for (int i = 0; i < fill; i++)
						queue_field(win[i], 1'b0, 1'b0);
			end
			queue_field(8'h00, 1'b1, f < 0);
			foreach (win[i])
				win[i] = '0;
			fill = '0;
			cur_fld = 16'd1;
			fld_done = 1'b0;
			n_strings++;
		end
	endfunction

	// ---------------------------------------------------------------- receiver

	always @(negedge clk) begin
		if (hold_left > 0) begin
			field_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else
			field_stall <= !calm && $urandom_range(99) < 15;
	end

	always @(posedge clk) begin
		if (arst_n && field_valid && !field_stall) begin
			if (pending_fields.size() == 0) begin
				n_fail++;
				if (n_fail <= 10)
					$display("unexpected field transaction at %0t: byte %h end %b null %b",
						$realtime, field_item.field_byte, field_item.is_end,
						field_item.is_null);
			end else begin
				want = pending_fields.pop_front();
				if (field_item.field_byte !== want.field_byte ||
						field_item.is_end !== want.is_end ||
						field_item.is_null !== want.is_null) begin
					n_fail++;
					if (n_fail <= 10)
						$display({"mismatch at %0t: expected byte %h end %b null %b, ",
							"got byte %h end %b null %b"}, $realtime,
							want.field_byte, want.is_end, want.is_null,
							field_item.field_byte, field_item.is_end, field_item.is_null);
				end
				n_results++;
				if (want.is_end && want.is_null)
					n_nulls++;
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// Enter and leave at a falling edge; valid stays high after the transaction.
	task automatic send_text(input byte_t b, input logic last, input logic empty);
		if (!calm && $urandom_range(99) < 7) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		text_valid <= 1'b1;
		text_item <= '{text_byte: b, text_last: last, text_empty: empty};
		do @(posedge clk); while (text_stall);
		predict_split(text_item);
		n_bytes++;
		@(negedge clk);
	endtask

	task automatic send_string(input bit mark_last, input bit close_empty);
		for (int i = 0; i < string_buf.size(); i++)
			send_text(string_buf[i], mark_last && !close_empty && i == string_buf.size() - 1,
				1'b0);
		if (close_empty || (mark_last && string_buf.size() == 0))
			send_text(byte_t'($urandom), 1'($urandom_range(1)), 1'b1);
	endtask

	task automatic wait_for_results();
		text_valid <= 1'b0;
		while (pending_fields.size() != 0)
			@(posedge clk);
		// let a transaction that caused no output settle inside the block
		repeat (4) @(negedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after its last write.
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_DELIM_BYTES:  dl_bytes = data;
			CFG_DELIM_LENGTH: dl_len = data[3:0];
			CFG_FIELD_NUMBER: fld_num = data[15:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
	endtask

	task automatic set_split(input logic [63:0] db, input logic [3:0] dl,
			input logic signed [15:0] fn);
		logic [63:0] d;
		wait_for_results();
		write_reg(CFG_DELIM_BYTES, db);
		// upper data bits are don't-care for the narrow registers
		d = {$urandom, $urandom};
		d[3:0] = dl;
		write_reg(CFG_DELIM_LENGTH, d);
		d = {$urandom, $urandom};
		d[15:0] = fn;
		write_reg(CFG_FIELD_NUMBER, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic build_string();
		int parts;
		int len;
		int r;
		len = eff_len();
		string_buf.delete();
		parts = ($urandom_range(9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 8);
		repeat (parts) begin
			r = $urandom_range(99);
			if (len == 0 || r >= 80)
				string_buf.push_back(byte_t'($urandom));
			else if (r < 35)
				for (int i = 0; i < len; i++)
					string_buf.push_back(delim_at(i));
			else if (r < 65)
				string_buf.push_back(delim_at($urandom_range(len - 1)));
			else
				// delimiter cut one byte short
				for (int i = 0; i < len - 1; i++)
					string_buf.push_back(delim_at(i));
		end
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_defaults();
		string_buf = '{8'h61, 8'h00, 8'h62};
		send_string(1'b1, 1'b0);
		wait_for_results();
		write_reg(CFG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
	endtask

	task automatic test_field_select();
		set_split(64'h2c, 4'd1, 16'sd2);
		string_buf = '{8'h78, 8'h2c, 8'h79, 8'h7a};
		send_string(1'b1, 1'b0);
		set_split(64'h2c, 4'd1, 16'sd0);
		string_buf = '{8'h2c, 8'h61};
		send_string(1'b1, 1'b0);
		set_split(64'h2c, 4'd1, -16'sd1);
		string_buf = '{8'h61};
		send_string(1'b1, 1'b0);
		// field past the end
		set_split(64'h2c, 4'd1, 16'sd7);
		string_buf = '{8'h61, 8'h2c, 8'h62};
		send_string(1'b1, 1'b0);
	endtask

	task automatic test_long_delim();
		set_split(64'h2d2d, 4'd2, 16'sd2);
		string_buf = '{8'h61, 8'h2d, 8'h2d, 8'h2d, 8'h62};
		send_string(1'b1, 1'b0);
	endtask

	task automatic test_zero_length();
		set_split({$urandom, $urandom}, 4'd0, 16'sd3);
		string_buf = '{8'h68, 8'h69};
		send_string(1'b1, 1'b0);
	endtask

	task automatic test_empty_strings();
		send_text(8'hff, 1'b1, 1'b1);
		send_text(8'h00, 1'b0, 1'b1);
		// empty flag closes a string that has bytes
		string_buf = '{8'h71};
		send_string(1'b0, 1'b1);
	endtask

	task automatic test_config_mid_string();
		set_split(64'h6261, 4'd2, 16'sd1);
		string_buf = '{8'h78, 8'h61};
		send_string(1'b0, 1'b0);
		set_split(64'h61, 4'd1, 16'sd1);
		string_buf = '{8'h62};
		send_string(1'b1, 1'b0);
	endtask

	task automatic test_backpressure();
		set_split(64'h0, 4'd0, 16'sd1);
		@(posedge clk);
		hold_left = 300;
		@(negedge clk);
		string_buf.delete();
		repeat (40)
			string_buf.push_back(byte_t'($urandom));
		send_string(1'b1, 1'b0);
	endtask

	task automatic test_random();
		int start;
		int r;
		logic [63:0] db;
		logic [3:0] dl;
		logic signed [15:0] fn;
		byte_t rep;
		start = n_bytes;
		while (n_bytes - start < 210) begin
			case ($urandom_range(9))
				0:       dl = 4'd0;
				1, 2:    dl = 4'd1;
				3, 4:    dl = 4'd2;
				5:       dl = 4'd3;
				6:       dl = 4'd8;
				7:       dl = 4'($urandom_range(9, 15));
				default: dl = 4'($urandom_range(0, 8));
			endcase
			if ($urandom_range(3) == 0) begin
				rep = byte_t'($urandom);
				db = {8{rep}};
			end else
				db = {$urandom, $urandom};
			case ($urandom_range(11))
				0:       fn = -16'sd1;
				1:       fn = -16'sd32768;
				2:       fn = 16'sd32767;
				3:       fn = 16'sd0;
				4:       fn = 16'($urandom);
				default: fn = 16'($urandom_range(1, 4));
			endcase
			set_split(db, dl, fn);
			calm = (n_bytes - start >= 70 && n_bytes - start < 140);
			repeat ($urandom_range(2, 6)) begin
				if (n_bytes - start >= 210)
					break;
				build_string();
				r = $urandom_range(99);
				if (r < 8)
					send_string(1'b0, 1'b1);
				else if (r < 14)
					send_string(1'b0, 1'b0);
				else
					send_string(1'b1, 1'b0);
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		foreach (win[i])
			win[i] = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_defaults();
		test_field_select();
		test_long_delim();
		test_zero_length();
		test_empty_strings();
		test_config_mid_string();
		test_backpressure();
		test_random();
		wait_for_results();
		repeat (16) @(posedge clk);
		$display("covered %0d strings of %0d text transactions under %0d register writes",
			n_strings, n_bytes, n_writes);
		$display("checked %0d field transactions, %0d of them null ends, %0d failures",
			n_results, n_nulls, n_fail);
		if (n_fail == 0 && pending_fields.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### delimited_field_extractor.f
src/dfe_pkg.sv
src/delimited_field_extractor.sv
bench/delimited_field_extractor_tb.sv
